// ===== hw/rtl/mbt_pkg.sv =====
// ----------------------------------------------------------------------------
// mbt_pkg
// Shared constants and codes for the secure network beacon tracker.
// ----------------------------------------------------------------------------
package mbt_pkg;

    localparam int RING_DEPTH = 16;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);

    localparam int IV_WINDOW  = 48;
    localparam int MS_PER_S   = 1000;
    localparam int BYTE_W     = 8;

    localparam int DIVD_W     = 12 + CNT_W;
    localparam int BIT_W      = $clog2(DIVD_W);

    typedef enum logic [1:0] {
        OP_RECEIVE = 2'd0,
        OP_TICK    = 2'd1,
        OP_START   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        IV_NONE    = 3'd0,
        IV_START   = 3'd1,
        IV_RECOVER = 3'd2,
        IV_STOP    = 3'd3,
        IV_TOO_OLD = 3'd4
    } iv_action_t;

    typedef enum logic [1:0] {
        CFG_NETWORK_ID = 2'd0,
        CFG_PERIOD     = 2'd1,
        CFG_EXPECTED   = 2'd2
    } cfg_index_t;

endpackage

// ===== hw/rtl/mesh_secure_beacon_tracker.sv =====
// ----------------------------------------------------------------------------
// mesh_secure_beacon_tracker
// Secure network beacon checker, IV index classifier and send interval timer.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  s_*      in   s_valid / s_ready    operation, beacon fields, now_seconds
//  m_*      out  m_valid / m_ready    accepted, iv_action, new_iv, interval, count
//  cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  receive beats pass the check state before the result; start and unused beats
//  go straight to it; tick beats walk the ring, then multiply, divide and scale:
//  the ring walk and the restoring divider share one subtractor, one step per cycle
//  s_ready is high only while the sequencer is idle; a finished result waits
//  in the output register, so a new beat is taken while m_valid stalls
//  aresetn clears the sequencer, ring valid bits, pointer and last auth, and resets config
// ----------------------------------------------------------------------------
module mesh_secure_beacon_tracker
    import mbt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [63:0] s_beacon_network_id,
    input  logic [63:0] s_received_auth,
    input  logic [63:0] s_computed_auth,
    input  logic        s_update_flag,
    input  logic [31:0] s_beacon_iv,
    input  logic [31:0] s_local_iv,
    input  logic [15:0] s_now_seconds,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accepted,
    output logic [2:0]  m_iv_action,
    output logic [31:0] m_new_iv,
    output logic [25:0] m_interval_ms,
    output logic [4:0]  m_recent_count,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RECV,
        ST_WALK,
        ST_MULT,
        ST_DIV,
        ST_SCALE,
        ST_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [63:0]       net_id_reg;
    logic [11:0]       period_reg;
    logic [7:0]        expected_reg;

    // beacon history
    logic [15:0]       stamp_reg [RING_DEPTH];
    logic [RING_DEPTH-1:0] stamp_valid_reg;
    logic [PTR_W-1:0]  ptr_reg;
    logic [63:0]       last_auth_reg;

    // latched beat
    logic [63:0]       nid_reg;
    logic [63:0]       rauth_reg;
    logic [63:0]       cauth_reg;
    logic              flag_reg;
    logic [31:0]       biv_reg;
    logic [31:0]       liv_reg;
    logic [15:0]       now_reg;

    // working registers
    logic [CNT_W-1:0]  count_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [7:0]        rem_reg;
    logic [BIT_W-1:0]  bit_reg;

    // results
    logic              res_acc_reg;
    logic [2:0]        res_action_reg;
    logic [31:0]       res_niv_reg;
    logic [25:0]       res_ms_reg;
    logic [CNT_W-1:0]  res_count_reg;

    // output register
    logic              m_valid_reg;
    logic              m_acc_reg;
    logic [2:0]        m_action_reg;
    logic [31:0]       m_niv_reg;
    logic [25:0]       m_ms_reg;
    logic [4:0]        m_count_reg;
    logic              out_load;

    // ---------------- walk slot ----------------
    logic [CNT_W:0]    ptr_ext;
    logic [CNT_W:0]    cnt_ext;
    logic [PTR_W-1:0]  slot;
    logic [PTR_W-1:0]  ptr_next;

    assign ptr_ext = (CNT_W+1)'(ptr_reg);
    assign cnt_ext = (CNT_W+1)'(count_reg);
    assign slot = (ptr_ext >= cnt_ext) ? PTR_W'(ptr_ext - cnt_ext)
                                       : PTR_W'(ptr_ext + (CNT_W+1)'(RING_DEPTH) - cnt_ext);
    assign ptr_next = (ptr_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;

    // ---------------- shared subtractor ----------------
    logic [8:0]  div_shift;
    logic [7:0]  divisor;
    logic [15:0] sub_a;
    logic [15:0] sub_b;
    logic [16:0] sub_y;

    assign div_shift = {rem_reg, quo_reg[DIVD_W-1]};
    assign divisor   = (expected_reg == '0) ? 8'd1 : expected_reg;

    always_comb begin
        if (state_reg == ST_DIV) begin
            sub_a = 16'(div_shift);
            sub_b = 16'(divisor);
        end else begin
            sub_a = now_reg;
            sub_b = stamp_reg[slot];
        end
    end

    assign sub_y = {1'b0, sub_a} - {1'b0, sub_b};

    logic walk_hit;
    assign walk_hit = (count_reg < CNT_W'(RING_DEPTH)) && stamp_valid_reg[slot]
                      && (sub_y[15:0] <= {4'b0, period_reg});

    // ---------------- receive checks ----------------
    logic [32:0] b33;
    logic [32:0] l33;
    logic [32:0] l_plus1;
    logic [32:0] l_plus_w;
    logic [32:0] b_plus_w;
    logic        beacon_ok;
    iv_action_t  action;

    assign b33      = {1'b0, biv_reg};
    assign l33      = {1'b0, liv_reg};
    assign l_plus1  = l33 + 33'd1;
    assign l_plus_w = l33 + 33'(IV_WINDOW);
    assign b_plus_w = b33 + 33'(IV_WINDOW);

    assign beacon_ok = (nid_reg == net_id_reg) && (rauth_reg != last_auth_reg)
                       && (cauth_reg == rauth_reg);

    always_comb begin
        if (b33 == l_plus1) begin
            action = flag_reg ? IV_START : IV_RECOVER;
        end else if (b33 > l_plus1 && b33 < l_plus_w) begin
            action = IV_RECOVER;
        end else if (!flag_reg && b33 == l33) begin
            action = IV_STOP;
        end else if (b_plus_w < l33) begin
            action = IV_TOO_OLD;
        end else begin
            action = IV_NONE;
        end
    end

    logic [DIVD_W+9:0] ms_full;
    assign ms_full = (DIVD_W+10)'(quo_reg) * (DIVD_W+10)'(MS_PER_S);

    // result moves into the output register when it is free or draining
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            net_id_reg      <= '0;
            period_reg      <= 12'd120;
            expected_reg    <= 8'd10;
            stamp_valid_reg <= '0;
            ptr_reg         <= '0;
            last_auth_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_NETWORK_ID: net_id_reg   <= cfg_data;
                    CFG_PERIOD:     period_reg   <= cfg_data[11:0];
                    CFG_EXPECTED:   expected_reg <= cfg_data[BYTE_W-1:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        nid_reg        <= s_beacon_network_id;
                        rauth_reg      <= s_received_auth;
                        cauth_reg      <= s_computed_auth;
                        flag_reg       <= s_update_flag;
                        biv_reg        <= s_beacon_iv;
                        liv_reg        <= s_local_iv;
                        now_reg        <= s_now_seconds;
                        count_reg      <= CNT_W'(1);
                        res_acc_reg    <= 1'b0;
                        res_action_reg <= IV_NONE;
                        res_niv_reg    <= '0;
                        res_ms_reg     <= '0;
                        res_count_reg  <= '0;
                        case (s_operation)
                            OP_RECEIVE: state_reg <= ST_RECV;
                            OP_TICK:    state_reg <= ST_WALK;
                            OP_START: begin
                                stamp_valid_reg <= '0;
                                state_reg       <= ST_OUT;
                            end
                            default:    state_reg <= ST_OUT;
                        endcase
                    end
                end
                ST_RECV: begin
                    if (beacon_ok) begin
                        res_acc_reg    <= 1'b1;
                        res_action_reg <= action;
                        res_niv_reg    <= (action == IV_RECOVER) ? biv_reg : '0;
                        if (action != IV_TOO_OLD) begin
                            last_auth_reg            <= rauth_reg;
                            stamp_reg[ptr_reg]       <= now_reg;
                            stamp_valid_reg[ptr_reg] <= 1'b1;
                            ptr_reg                  <= ptr_next;
                        end
                    end
                    state_reg <= ST_OUT;
                end
                ST_WALK: begin
                    // one ring slot per cycle, newest first
                    if (walk_hit) begin
                        count_reg <= count_reg + 1'b1;
                    end else begin
                        state_reg <= ST_MULT;
                    end
                end
                ST_MULT: begin
                    quo_reg       <= DIVD_W'(period_reg) * DIVD_W'(count_reg);
                    rem_reg       <= '0;
                    bit_reg       <= BIT_W'(DIVD_W - 1);
                    res_count_reg <= count_reg;
                    state_reg     <= ST_DIV;
                end
                ST_DIV: begin
                    // restoring division, one quotient bit per cycle
                    rem_reg <= sub_y[16] ? div_shift[7:0] : sub_y[7:0];
                    quo_reg <= {quo_reg[DIVD_W-2:0], ~sub_y[16]};
                    bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == '0) begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    res_ms_reg <= 26'(ms_full);
                    state_reg  <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        m_acc_reg    <= res_acc_reg;
                        m_action_reg <= res_action_reg;
                        m_niv_reg    <= res_niv_reg;
                        m_ms_reg     <= res_ms_reg;
                        m_count_reg  <= 5'(res_count_reg);
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign cfg_ready      = 1'b1;
    assign m_valid        = m_valid_reg;
    assign m_accepted     = m_acc_reg;
    assign m_iv_action    = m_action_reg;
    assign m_new_iv       = m_niv_reg;
    assign m_interval_ms  = m_ms_reg;
    assign m_recent_count = m_count_reg;

    // ---------------- assertions ----------------
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a beat is in flight");

    a_walk_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> count_reg >= CNT_W'(1) && count_reg <= CNT_W'(RING_DEPTH))
        else $error("walk count out of range");

    a_tick_not_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_recent_count != 5'd0 |-> !m_accepted && m_iv_action == IV_NONE)
        else $error("tick result carries beacon fields");

    a_action_needs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_iv_action != IV_NONE |-> m_accepted && m_interval_ms == 26'd0)
        else $error("iv action without accepted beacon");

    a_new_iv_recover: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_new_iv != 32'd0 |-> m_iv_action == IV_RECOVER)
        else $error("new iv set without recover");

endmodule
